// ===== src/assert_macros.svh =====
// Assertion shorthands used by the checker file.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SDQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted delay queue check failed");

// Next-cycle implication.
`define SDQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted delay queue check failed");

`endif

// ===== src/sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdq_pkg
// Types and constants shared by the sorted delay queue files.
// ----------------------------------------------------------------------------
package sdq_pkg;

	localparam int unsigned PADDR_W = 3;
	localparam logic [31:0] TPS_RESET = 32'd1000000;

	// register index taken from paddr[2]
	localparam logic REG_IDX_TPS = 1'b0;

	typedef enum logic [2:0] {
		STAT_QUEUED = 3'd0,
		STAT_ZERO   = 3'd1,
		STAT_FULL   = 3'd2,
		STAT_NEG    = 3'd3,
		STAT_WOKEN  = 3'd4,
		STAT_DONE   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_SHIFT,
		S_PLACE,
		S_TREAD,
		S_TCHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic               mode;
		logic [3:0]         requester_id;
		logic signed [31:0] sleep_seconds;
		logic [47:0]        now_time;
	} sdq_in_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] woken_id;
		logic       last;
	} sdq_out_t;

endpackage

// ===== src/sdq_ram.sv =====
// ----------------------------------------------------------------------------
// sdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sdq_ram #(
	parameter int WIDTH = 52,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/sorted_delay_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_delay_queue_core
// Bounded list of sleeping requesters sorted by wake time, held in a RAM
// used as a ring (head pointer plus count).
// ----------------------------------------------------------------------------
//  channel   | signals                               | transfer when
//  ----------+---------------------------------------+----------------------------
//  request   | start, busy, req                      | start && !busy
//  result    | result_strobe, result                 | result_strobe (no stall)
//  config    | psel penable pwrite paddr pwdata ...  | psel && penable && pwrite
//
// Zero, negative or full delay requests and ticks on an empty list answer in
// the cycle after the transfer. An insert computes the wake time, then moves
// later entries one slot back (one per cycle, bounded by the RAM's single
// write port) and writes its entry with the result. A tick reads the head,
// then sends a wake notice per due entry and one done item. No clearing pass
// after reset. Results cannot be stalled.
module sorted_delay_queue_core
	import sdq_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sdq_in_t            req,
	output logic               result_strobe,
	output sdq_out_t           result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int DW = TIME_BITS + 4;

	state_t state_q, state_d;

	sdq_in_t              item_q;
	logic [31:0]          tps_q;
	logic [AW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        k_q;
	logic [62:0]          prod_q;
	logic [TIME_BITS-1:0] wake_q;
	logic                 res_strobe_q;
	sdq_out_t             res_q;

	logic                 accept;
	logic                 full;
	logic [62:0]          prod_d;
	logic [64:0]          sum65;
	logic [TIME_BITS-1:0] wake_d;
	logic [63:0]          now64;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] rd_wake;
	logic [3:0]           rd_id;
	logic                 move;
	logic                 due;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [DW-1:0]        ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [DW-1:0]        ram_rdata;
	logic                 strobe_d;
	sdq_out_t             res_d;

	// logical slot -> physical RAM address; base + ofs stays below 2*MAX_ENTRIES
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
	                                       input logic [CW-1:0] ofs);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(ofs);
		if (s >= (CW+1)'(MAX_ENTRIES)) begin
			s = s - (CW+1)'(MAX_ENTRIES);
		end
		return s[AW-1:0];
	endfunction

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign full   = (count_q == CW'(MAX_ENTRIES));

	assign now64 = 64'(item_q.now_time);
	assign now_t = now64[TIME_BITS-1:0];

	assign prod_d = 63'(item_q.sleep_seconds[30:0]) * 63'(tps_q);
	assign sum65  = 65'(prod_q) + 65'(now_t);
	assign wake_d = (|(sum65 >> TIME_BITS)) ? {TIME_BITS{1'b1}} : sum65[TIME_BITS-1:0];

	assign rd_wake = ram_rdata[DW-1:4];
	assign rd_id   = ram_rdata[3:0];

	// examining slot k-1; the head keeps its place on a tie
	assign move = (k_q == CW'(1)) ? (wake_q < rd_wake) : (rd_wake >= wake_q);
	assign due  = (rd_wake <= now_t);

	sdq_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!req.mode) begin
						if (req.sleep_seconds != 32'sd0 && !req.sleep_seconds[31] && !full) begin
							state_d = S_MUL;
						end
					end else if (count_q != '0) begin
						state_d = S_TREAD;
					end
				end
			end
			S_MUL:   state_d = S_ADD;
			S_ADD:   state_d = (count_q == '0) ? S_PLACE : S_SHIFT;
			S_SHIFT: begin
				if (move) begin
					state_d = (k_q == CW'(1)) ? S_PLACE : S_SHIFT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_PLACE: state_d = S_IDLE;
			S_TREAD: state_d = S_TCHK;
			S_TCHK: begin
				if (due) begin
					state_d = (count_q == CW'(1)) ? S_DONE : S_TCHK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: RAM control and the next result
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, k_q);
		ram_wdata = {wake_q, item_q.requester_id};
		ram_raddr = head_q;
		strobe_d  = 1'b0;
		res_d     = '{status: STAT_QUEUED, woken_id: 4'd0, last: 1'b1};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!req.mode) begin
						if (req.sleep_seconds == 32'sd0) begin
							strobe_d     = 1'b1;
							res_d.status = STAT_ZERO;
						end else if (req.sleep_seconds[31]) begin
							strobe_d     = 1'b1;
							res_d.status = STAT_NEG;
						end else if (full) begin
							strobe_d     = 1'b1;
							res_d.status = STAT_FULL;
						end
					end else if (count_q == '0) begin
						strobe_d     = 1'b1;
						res_d.status = STAT_DONE;
					end
				end
			end
			S_ADD: begin
				ram_raddr = phys(head_q, count_q - CW'(1));
			end
			S_SHIFT: begin
				ram_raddr = phys(head_q, k_q - CW'(2));
				ram_we    = 1'b1;
				if (move) begin
					ram_wdata = ram_rdata;
				end else begin
					strobe_d = 1'b1;
				end
			end
			S_PLACE: begin
				ram_we   = 1'b1;
				strobe_d = 1'b1;
			end
			S_TREAD: begin
				ram_raddr = head_q;
			end
			S_TCHK: begin
				ram_raddr = phys(head_q, CW'(1));
				strobe_d  = 1'b1;
				if (due) begin
					res_d.status   = STAT_WOKEN;
					res_d.woken_id = rd_id;
					res_d.last     = 1'b0;
				end else begin
					res_d.status = STAT_DONE;
				end
			end
			S_DONE: begin
				strobe_d     = 1'b1;
				res_d.status = STAT_DONE;
			end
			default: begin
				strobe_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			k_q          <= '0;
			res_strobe_q <= 1'b0;
			tps_q        <= TPS_RESET;
		end else begin
			state_q      <= state_d;
			res_strobe_q <= strobe_d;
			if (psel && penable && pwrite && paddr[2] == REG_IDX_TPS) begin
				tps_q <= pwdata;
			end
			case (state_q)
				S_ADD: k_q <= count_q;
				S_SHIFT: begin
					if (move) begin
						k_q <= k_q - CW'(1);
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				S_PLACE: count_q <= count_q + CW'(1);
				S_TCHK: begin
					if (due) begin
						head_q  <= phys(head_q, CW'(1));
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_d;
		end
		if (state_q == S_ADD) begin
			wake_q <= wake_d;
		end
		res_q <= res_d;
	end

	assign result_strobe = res_strobe_q;
	assign result        = res_q;
	assign prdata        = (paddr[2] == REG_IDX_TPS) ? tps_q : 32'd0;
	assign pready        = 1'b1;

endmodule

// ===== src/sdq_checker.sv =====
// ----------------------------------------------------------------------------
// sdq_checker
// Port-level checks on the sorted delay queue, bound to sorted_delay_queue_core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdq_checker
	import sdq_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     result_strobe,
	input sdq_out_t result
);

	// every transfer either answers at once or keeps the block busy
	`SDQ_ASSERT_NXT(a_accept_progress, start && !busy, busy || result_strobe)

	// no result without a transfer or ongoing work
	`SDQ_ASSERT_IMP(a_no_spurious, result_strobe, $past(busy) || $past(start))

	// only wake notices leave the transfer open
	`SDQ_ASSERT_IMP(a_last_rule, result_strobe, result.last == (result.status != STAT_WOKEN))

	// the final result of a transfer frees the request side
	`SDQ_ASSERT_IMP(a_last_idle, result_strobe && result.last, !busy)

	// only wake notices carry an id
	`SDQ_ASSERT_IMP(a_woken_id, result_strobe && result.status != STAT_WOKEN, result.woken_id == 4'd0)

endmodule

bind sorted_delay_queue_core sdq_checker u_sdq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.result        (result)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_delay_queue_core. A tracker class keeps its
// own sorted wake list and tick rate, predicts every result of each accepted
// request, and checks the result stream field by field in order. Directed
// requests cover zero, negative and full-list cases, head ties, saturation
// and empty ticks. Random phases then run at several tick rates with changing
// sender idle rates. The rate register is written and read back over APB.
// ----------------------------------------------------------------------------
module tb;
	import sdq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int TIME_W      = 48;
	localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF;
	localparam logic [PADDR_W-1:0] TPS_ADDR   = {REG_IDX_TPS, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_IDX_TPS, 2'b00};

	class wake_order_tracker;
		bit [31:0] tick_rate;
		bit [TIME_W-1:0] wake_list[$];
		logic [3:0] id_list[$];
		sdq_out_t pending_results[$];
		int errors;
		int requests;
		int woken;
		int full_hits;

		function new();
			tick_rate = TPS_RESET;
			errors = 0;
			requests = 0;
			woken = 0;
			full_hits = 0;
		endfunction

		function bit [TIME_W-1:0] wake_of(bit [31:0] secs, bit [TIME_W-1:0] now);
			bit [63:0] sum;
			sum = 64'(secs) * 64'(tick_rate) + 64'(now);
			if (sum > TIME_MAX)
				return '1;
			return sum[TIME_W-1:0];
		endfunction

		function void note_request(sdq_in_t item);
			bit [TIME_W-1:0] wake;
			int pos;
			sdq_out_t r;
			requests++;
			r = '0;
			if (item.mode == 1'b0) begin
				r.last = 1'b1;
				if (item.sleep_seconds == 0) begin
					r.status = STAT_ZERO;
				end else if (item.sleep_seconds[31]) begin
					// sign is checked before fullness
					r.status = STAT_NEG;
				end else if (wake_list.size() >= QUEUE_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					wake = wake_of(item.sleep_seconds, item.now_time);
					// a tie with the head lands behind it; elsewhere ahead of equals
					if (wake_list.size() == 0 || wake < wake_list[0]) begin
						pos = 0;
					end else begin
						pos = 1;
						while (pos < wake_list.size() && wake_list[pos] < wake)
							pos++;
					end
					wake_list.insert(pos, wake);
					id_list.insert(pos, item.requester_id);
					r.status = STAT_QUEUED;
				end
				pending_results.push_back(r);
			end else begin
				while (wake_list.size() > 0 && wake_list[0] <= item.now_time) begin
					r.status = STAT_WOKEN;
					r.woken_id = id_list.pop_front();
					r.last = 1'b0;
					void'(wake_list.pop_front());
					pending_results.push_back(r);
				end
				r.status = STAT_DONE;
				r.woken_id = '0;
				r.last = 1'b1;
				pending_results.push_back(r);
			end
		endfunction

		function void check_result(sdq_out_t got);
			sdq_out_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status=%0d id=%0d last=%0d",
					$time, got.status, got.woken_id, got.last);
				return;
			end
			want = pending_results.pop_front();
			if (want.status == STAT_WOKEN)
				woken++;
			if (want.status == STAT_FULL)
				full_hits++;
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status expected %0d actual %0d",
					$time, want.status, got.status);
			end
			if (got.woken_id !== want.woken_id) begin
				errors++;
				$display("%0t: woken_id expected %0d actual %0d",
					$time, want.woken_id, got.woken_id);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last expected %0d actual %0d",
					$time, want.last, got.last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sdq_in_t req = '0;
	logic result_strobe;
	sdq_out_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	wake_order_tracker tracker = new();
	bit [TIME_W-1:0] cur_now;
	int send_idle;
	int i;

	sorted_delay_queue_core #(
		.MAX_ENTRIES(QUEUE_DEPTH),
		.TIME_BITS(TIME_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.result_strobe(result_strobe),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			tracker.check_result(result);
	end

	function automatic sdq_in_t make_item(logic mode, logic [3:0] id, logic [31:0] secs,
		logic [TIME_W-1:0] now);
		sdq_in_t item;
		item.mode = mode;
		item.requester_id = id;
		item.sleep_seconds = secs;
		item.now_time = now;
		return item;
	endfunction

	task automatic send_request(input sdq_in_t item);
		if (send_idle != 0 && $urandom_range(99) < send_idle) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy);
		tracker.note_request(item);
	endtask

	// block must be idle before any register access
	task automatic drain();
		start <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[2] == REG_IDX_TPS)
			tracker.tick_rate = value;
		@(posedge clk);
	endtask

	task automatic verify_rate();
		logic [31:0] data;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= TPS_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (data !== tracker.tick_rate) begin
			tracker.errors++;
			$display("%0t: ticks_per_second readback expected %0d actual %0d",
				$time, tracker.tick_rate, data);
		end
		@(posedge clk);
	endtask

	task automatic pick_request(output sdq_in_t item);
		bit [63:0] wide;
		int k;
		wide = {$urandom, $urandom};
		item.requester_id = $urandom_range(15);
		item.sleep_seconds = $urandom;
		item.now_time = wide[TIME_W-1:0];
		if ($urandom_range(99) < 60) begin
			item.mode = 1'b0;
			k = $urandom_range(99);
			if (k < 5)
				item.sleep_seconds = 0;
			else if (k >= 15)
				item.sleep_seconds = $urandom_range(6, 1);
			// mostly the running clock so wake times meet later ticks
			if ($urandom_range(19) != 0)
				item.now_time = cur_now;
		end else begin
			item.mode = 1'b1;
			if ($urandom_range(29) != 0) begin
				wide = 64'(cur_now) + 64'($urandom_range(3)) * 64'(tracker.tick_rate)
					+ 64'($urandom_range(1));
				if (wide > TIME_MAX)
					wide = TIME_MAX;
				cur_now = wide[TIME_W-1:0];
				item.now_time = cur_now;
			end else begin
				item.now_time = '1;
			end
		end
	endtask

	task automatic run_phase(input int count, input int idle_pct);
		sdq_in_t item;
		send_idle = idle_pct;
		cur_now = $urandom_range(1000);
		repeat (count) begin
			pick_request(item);
			send_request(item);
		end
		// empty the list so the next rate starts clean
		send_request(make_item(1'b1, 4'd0, 32'd0, '1));
		drain();
	endtask

	initial begin
		send_idle = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_rate();

		// directed: reset tick rate
		send_request(make_item(1'b1, 4'd0, 32'd0, '0));
		send_request(make_item(1'b0, 4'd9, 32'd0, 48'd100));
		send_request(make_item(1'b0, 4'd9, 32'h8000_0000, 48'd100));
		send_request(make_item(1'b0, 4'd9, 32'hFFFF_FFFF, 48'd100));
		send_request(make_item(1'b0, 4'd0, 32'h7FFF_FFFF, '1));
		send_request(make_item(1'b0, 4'd1, 32'd5, 48'd0));
		send_request(make_item(1'b0, 4'd2, 32'd5, 48'd0));
		send_request(make_item(1'b0, 4'd3, 32'd4, 48'd1000000));
		send_request(make_item(1'b0, 4'd4, 32'd9, 48'd0));
		send_request(make_item(1'b0, 4'd5, 32'd9, 48'd0));
		send_request(make_item(1'b0, 4'd6, 32'd1, 48'd0));
		for (i = 7; i < 16; i++)
			send_request(make_item(1'b0, 4'(i), 32'(i), 48'(i)));
		send_request(make_item(1'b0, 4'd15, 32'd3, 48'd0));
		send_request(make_item(1'b0, 4'd15, 32'hFFFF_FFFE, 48'd0));
		send_request(make_item(1'b0, 4'd15, 32'd0, 48'd0));
		send_request(make_item(1'b1, 4'd0, 32'd0, 48'd5000000));
		send_request(make_item(1'b1, 4'd0, 32'd0, '1));
		drain();

		// write to an unmapped slot must leave the rate alone
		apb_write(SPARE_ADDR, 32'd7);
		verify_rate();
		apb_write(TPS_ADDR, 32'd1);
		verify_rate();
		run_phase(70, 17);

		apb_write(TPS_ADDR, 32'hFFFF_FFFF);
		verify_rate();
		run_phase(70, 85);

		apb_write(TPS_ADDR, ($urandom % 32'hFFFF_FFFF) + 32'd1);
		verify_rate();
		run_phase(70, 0);

		repeat (20) @(posedge clk);
		$display("Summary: %0d requests checked, %0d wakeups, %0d full-list rejects",
			tracker.requests, tracker.woken, tracker.full_hits);
		$display("Tick rates covered: reset value, 1, all ones and one random value");
		if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", tracker.pending_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
